[hdl/pfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam int MAX_MESSAGES = 8;
  localparam int FRAME_CAP    = 2 + 4 * MAX_MESSAGES;
  localparam int CW           = $clog2(FRAME_CAP + 2);
  localparam int RAM_AW       = $clog2(FRAME_CAP);

  typedef logic [CW-1:0]     cnt_t;
  typedef logic [RAM_AW-1:0] addr_t;

  typedef struct packed {
    logic       start;
    cnt_t       size;
    logic [7:0] sum;
    logic       drop;
  } emit_req_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WRITE = 3'b010,
    S_EMIT  = 3'b100
  } col_state_t;

endpackage

`default_nettype wire

[hdl/pfc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfc_ram #(
  parameter int W = 8,
  parameter int D = 34
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [$clog2(D)-1:0] wr_addr,
  input  wire logic [W-1:0]         wr_data,
  input  wire logic                 rd_en,
  input  wire logic [$clog2(D)-1:0] rd_addr,
  output logic      [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/pfc_collect.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfc_collect (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_destination,
  input  wire logic [7:0]        in_msg_type,
  input  wire logic [7:0]        in_msg_id,
  input  wire logic [15:0]       in_msg_value,
  input  wire logic              in_has_message,
  input  wire logic              in_last,
  output logic                   wr_en,
  output pfc_pkg::addr_t         wr_addr,
  output logic [7:0]             wr_data,
  output pfc_pkg::emit_req_t     req,
  input  wire logic              done
);

  import pfc_pkg::*;

  col_state_t      state_r, state_nxt;
  cnt_t            cnt_r, cnt_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic            drop_r, drop_nxt;
  logic            last_r, last_nxt;
  logic            start_r, start_nxt;
  logic [2:0]      wn_r, wn_nxt;
  addr_t           waddr_r, waddr_nxt;
  logic [4:0][7:0] wbuf_r, wbuf_nxt;

  logic            open;
  cnt_t            base;
  logic [CW:0]     room;
  logic            fit;
  logic [2:0]      n;
  logic [7:0]      msum;

  assign open = (cnt_r == '0);
  assign base = open ? cnt_t'(2) : cnt_r;
  assign room = {1'b0, base} + (CW+1)'(4);
  assign fit  = in_has_message && (room <= (CW+1)'(FRAME_CAP));
  assign n    = (open ? 3'd1 : 3'd0) + (fit ? 3'd4 : 3'd0);
  assign msum = in_msg_type + in_msg_id + in_msg_value[15:8] + in_msg_value[7:0];

  assign in_ready = (state_r == S_IDLE);
  assign wr_addr  = waddr_r;
  assign wr_data  = wbuf_r[0];

  always_comb begin
    req.start = start_r;
    req.size  = cnt_r;
    req.sum   = sum_r;
    req.drop  = drop_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    drop_nxt  = drop_r;
    last_nxt  = last_r;
    start_nxt = 1'b0;
    wn_nxt    = wn_r;
    waddr_nxt = waddr_r;
    wbuf_nxt  = wbuf_r;
    wr_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt  = fit ? cnt_t'(room) : base;
          sum_nxt  = (open ? in_destination : sum_r) + (fit ? msum : 8'd0);
          drop_nxt = drop_r | (in_has_message & ~fit);
          last_nxt = in_last;
          wn_nxt   = n;
          if (open) begin
            waddr_nxt = addr_t'(1);
            wbuf_nxt  = {in_msg_value[7:0], in_msg_value[15:8], in_msg_id, in_msg_type,
                         in_destination};
          end else begin
            waddr_nxt = cnt_r[RAM_AW-1:0];
            wbuf_nxt  = {in_msg_value[7:0], in_msg_value[7:0], in_msg_value[15:8],
                         in_msg_id, in_msg_type};
          end
          if (n != 3'd0) begin
            state_nxt = S_WRITE;
          end else if (in_last) begin
            state_nxt = S_EMIT;
            start_nxt = 1'b1;
          end
        end
      end
      S_WRITE: begin
        wr_en     = 1'b1;
        wbuf_nxt  = {wbuf_r[4], wbuf_r[4:1]};
        wn_nxt    = wn_r - 3'd1;
        waddr_nxt = waddr_r + addr_t'(1);
        if (wn_r == 3'd1) begin
          if (last_r) begin
            state_nxt = S_EMIT;
            start_nxt = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (done) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      drop_r  <= 1'b0;
      start_r <= 1'b0;
      wn_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      drop_r  <= drop_nxt;
      start_r <= start_nxt;
      wn_r    <= wn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    waddr_r <= waddr_nxt;
    wbuf_r  <= wbuf_nxt;
  end

  a_write_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> wn_r != 3'd0)
    else $error("write phase with nothing to write");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(FRAME_CAP))
    else $error("byte count beyond frame capacity");

  a_start_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> state_r == S_EMIT)
    else $error("emit start outside emit phase");

endmodule

`default_nettype wire

[hdl/pfc_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module pfc_emit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfc_pkg::emit_req_t req,
  output logic                   done,
  output logic                   rd_en,
  output pfc_pkg::addr_t         rd_addr,
  input  wire logic [7:0]        rd_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_frame_byte,
  output logic                   out_last_byte,
  output logic                   out_overflow
);

  import pfc_pkg::*;

  logic       active_r, active_nxt;
  cnt_t       ridx_r, ridx_nxt;
  logic       pv_r, pv_nxt;
  cnt_t       pidx_r, pidx_nxt;
  cnt_t       mark_r, mark_nxt;
  cnt_t       size_r;
  logic [7:0] sum_r;
  logic       drop_r;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r;
  logic       ol_r;
  logic       oo_r;

  logic       load;
  logic       issue;
  logic [7:0] raw;
  cnt_t       gap;
  logic [7:0] stuffed;

  assign load  = pv_r && (!ov_r || out_ready);
  assign issue = active_r && (!pv_r || load);
  assign done  = load && (pidx_r == size_r);

  assign rd_en   = issue && (ridx_r < size_r);
  assign rd_addr = ridx_r[RAM_AW-1:0];

  // checksum up front, zero pad at the trailing position
  assign raw     = (pidx_r == '0) ? sum_r : ((pidx_r == size_r) ? 8'd0 : rd_data);
  assign gap     = pidx_r + cnt_t'(1) - mark_r;
  assign stuffed = (raw == 8'd0) ? 8'(gap) : raw;

  always_comb begin
    active_nxt = active_r;
    ridx_nxt   = ridx_r;
    pv_nxt     = pv_r;
    pidx_nxt   = pidx_r;
    mark_nxt   = mark_r;
    ov_nxt     = ov_r;
    if (req.start) begin
      active_nxt = 1'b1;
      ridx_nxt   = '0;
      mark_nxt   = '0;
    end else if (issue) begin
      pv_nxt   = 1'b1;
      pidx_nxt = ridx_r;
      ridx_nxt = ridx_r + cnt_t'(1);
      if (ridx_r == size_r) begin
        active_nxt = 1'b0;
      end
    end else if (load) begin
      pv_nxt = 1'b0;
    end
    if (load) begin
      ov_nxt = 1'b1;
      if (raw == 8'd0) begin
        mark_nxt = pidx_r + cnt_t'(1);
      end
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pv_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pv_r     <= pv_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= ridx_nxt;
    pidx_r <= pidx_nxt;
    mark_r <= mark_nxt;
    if (req.start) begin
      size_r <= req.size;
      sum_r  <= req.sum;
      drop_r <= req.drop;
    end
    if (load) begin
      ob_r <= stuffed;
      ol_r <= (pidx_r == size_r);
      oo_r <= drop_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_frame_byte = ob_r;
  assign out_last_byte  = ol_r;
  assign out_overflow   = oo_r;

  a_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ob_r != 8'd0)
    else $error("zero frame byte on output");

  a_done_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !active_r)
    else $error("frame finished with reads outstanding");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !active_r && !pv_r)
    else $error("new frame while previous one still in flight");

endmodule

`default_nettype wire

[hdl/packet_framer_checksum.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel | ports                                                    | accepted when
// input   | in_destination in_msg_type in_msg_id in_msg_value        | in_valid && in_ready
//         | in_has_message in_last                                   |
// output  | out_frame_byte out_last_byte out_overflow                | out_valid && out_ready
//
// a word is accepted, then its stored bytes (none, 1, 4 or 5) are written one by one,
// through the single write port of the frame memory
// a last word then streams size+1 bytes at one per cycle, while out_ready is high, through the memory read port
// no word is accepted while a frame is being written out
// synchronous active-low reset, no clearing pass; out_ready low stalls the read pipeline

module packet_framer_checksum (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_destination,
  input  wire logic [7:0]  in_msg_type,
  input  wire logic [7:0]  in_msg_id,
  input  wire logic [15:0] in_msg_value,
  input  wire logic        in_has_message,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte,
  output logic             out_overflow
);

  import pfc_pkg::*;

  logic      wr_en;
  addr_t     wr_addr;
  logic [7:0] wr_data;
  logic      rd_en;
  addr_t     rd_addr;
  logic [7:0] rd_data;
  emit_req_t req;
  logic      done;

  pfc_collect u_collect (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_destination (in_destination),
    .in_msg_type    (in_msg_type),
    .in_msg_id      (in_msg_id),
    .in_msg_value   (in_msg_value),
    .in_has_message (in_has_message),
    .in_last        (in_last),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .req            (req),
    .done           (done)
  );

  pfc_ram #(
    .W (8),
    .D (FRAME_CAP)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pfc_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .done           (done),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_overflow   (out_overflow)
  );

endmodule

`default_nettype wire
